// ----- sv/bqiir_pkg.sv -----
package bqiir_pkg;

   // field and storage widths
   localparam int SAMPLE_W    = 32;
   localparam int COEF_W      = 32;
   localparam int HIST_W      = 40;
   localparam int CHAN_W      = 3;
   localparam int CSR_IDX_W   = 3;
   // output history is multiplied in two pieces split at this bit
   localparam int GUARD_SPLIT = 16;

   // parameter defaults
   localparam int CHANNELS_DEFAULT  = 8;
   localparam int COEF_FRAC_DEFAULT = 28;

   // saturation limits
   localparam longint SAT16_MIN = -64'sd32768;
   localparam longint SAT16_MAX = 64'sd32767;
   localparam longint SAT32_MIN = -64'sd2147483648;
   localparam longint SAT32_MAX = 64'sd2147483647;

   // register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FEED_GAIN_NOW     = 3'd0,
      CSR_FEED_GAIN_PREV    = 3'd1,
      CSR_FEED_GAIN_PREV2   = 3'd2,
      CSR_BACK_GAIN_PREV    = 3'd3,
      CSR_BACK_GAIN_PREV2   = 3'd4,
      CSR_SAMPLE_WIDTH_MODE = 3'd5
   } csr_index_type;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [HIST_W-1:0]   hist_type;
   typedef logic signed [COEF_W-1:0]   coef_type;

   // one channel's history word in the state memory
   typedef struct packed {
      sample_type x1;
      sample_type x2;
      hist_type   y1;
      hist_type   y2;
   } hist_entry_type;

   // per-request tag that travels down the pipeline
   typedef struct packed {
      logic [CHAN_W-1:0] chan;
      logic              chan_ok;
      sample_type        x;
      sample_type        x1;
      hist_type          y1;
   } tag_type;

endpackage

// ----- sv/bqiir_if.sv -----
// request channel: channel number and input sample
interface bqiir_req_if;
   import bqiir_pkg::*;
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] channel;
   sample_type        sample_in;

   modport source (output valid, output channel, output sample_in, input ready);
   modport sink   (input valid, input channel, input sample_in, output ready);
endinterface

// response channel: filtered sample and clip flag
interface bqiir_rsp_if;
   import bqiir_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sample_out;
   logic       clipped;

   modport source (output valid, output sample_out, output clipped, input ready);
   modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

// register write channel
interface bqiir_csr_if;
   import bqiir_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [COEF_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/bqiir_ram.sv -----
module bqiir_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // registered read, holds when not enabled
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/biquad_iir_filter_multichannel_core.sv -----
// A request passes through pipeline stages 1 to 5 and then the response register.
// Throughput: one request per cycle while the response side is not back-pressuring;
//   a request for a channel still in the 5-stage pipeline waits until that channel's
//   history write-back has landed in the state memory.
// Reset: synchronous, active high; coefficients return to b0 = 1.0, others 0, mode
//   16-bit; per-channel valid bits clear so all history reads as zero at once.
module biquad_iir_filter_multichannel_core #(
   parameter int CHANNELS       = bqiir_pkg::CHANNELS_DEFAULT,
   parameter int COEF_FRAC_BITS = bqiir_pkg::COEF_FRAC_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   bqiir_req_if.sink   req_chan,
   bqiir_rsp_if.source rsp_chan,
   bqiir_csr_if.sink   csr_chan
);
   import bqiir_pkg::*;

   localparam int ADDR_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int ENTRY_W = $bits(hist_entry_type);
   localparam int ACC_W   = COEF_W + HIST_W + 2;
   localparam int PH_W    = COEF_W + HIST_W - GUARD_SPLIT;
   localparam int PL_W    = COEF_W + GUARD_SPLIT + 1;
   localparam int PX_W    = COEF_W + SAMPLE_W;

   localparam logic signed [ACC_W-1:0] HIST_MAX = (ACC_W'(1) <<< (HIST_W - 1)) - 1;
   localparam logic signed [ACC_W-1:0] HIST_MIN = -HIST_MAX - 1;
   localparam logic signed [ACC_W-1:0] S16_MAX  = ACC_W'(SAT16_MAX);
   localparam logic signed [ACC_W-1:0] S16_MIN  = ACC_W'(SAT16_MIN);
   localparam logic signed [ACC_W-1:0] S32_MAX  = ACC_W'(SAT32_MAX);
   localparam logic signed [ACC_W-1:0] S32_MIN  = ACC_W'(SAT32_MIN);

   // ---------------------------------------------------------------
   // configuration registers
   coef_type b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;
   logic     mode_ff;
   logic     csr_fire;

   assign csr_chan.ready = 1'b1;
   assign csr_fire       = csr_chan.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_ff   <= COEF_W'(64'd1 << COEF_FRAC_BITS);
         b1_ff   <= '0;
         b2_ff   <= '0;
         a1_ff   <= '0;
         a2_ff   <= '0;
         mode_ff <= 1'b0;
      end else if (csr_fire) begin
         case (csr_chan.index)
            CSR_FEED_GAIN_NOW:     b0_ff   <= csr_chan.data;
            CSR_FEED_GAIN_PREV:    b1_ff   <= csr_chan.data;
            CSR_FEED_GAIN_PREV2:   b2_ff   <= csr_chan.data;
            CSR_BACK_GAIN_PREV:    a1_ff   <= csr_chan.data;
            CSR_BACK_GAIN_PREV2:   a2_ff   <= csr_chan.data;
            CSR_SAMPLE_WIDTH_MODE: mode_ff <= csr_chan.data[0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // stage valids and load enables (bubbles collapse toward the output)
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff, rsp_valid_ff;
   logic s1_valid_in, s2_valid_in, s3_valid_in, s4_valid_in, s5_valid_in, rsp_valid_in;
   logic load1, load2, load3, load4, load5, load_out;

   tag_type s1_tag_ff, s2_tag_ff, s3_tag_ff, s4_tag_ff, s5_tag_ff;

   assign load_out = !rsp_valid_ff || rsp_chan.ready;
   assign load5    = !s5_valid_ff || load_out;
   assign load4    = !s4_valid_ff || load5;
   assign load3    = !s3_valid_ff || load4;
   assign load2    = !s2_valid_ff || load3;
   assign load1    = !s1_valid_ff || load2;

   // ---------------------------------------------------------------
   // request decode and same-channel interlock
   logic              req_fire;
   logic              req_ok;
   logic [ADDR_W-1:0] req_addr;
   logic              hazard;
   sample_type        req_x;

   assign req_ok   = 32'(req_chan.channel) < CHANNELS;
   assign req_addr = ADDR_W'(req_chan.channel);
   assign req_x    = mode_ff ? req_chan.sample_in
                             : {{(SAMPLE_W-16){req_chan.sample_in[15]}},
                                req_chan.sample_in[15:0]};

   always_comb begin
      hazard = 1'b0;
      if (req_ok) begin
         if (s1_valid_ff && s1_tag_ff.chan_ok && s1_tag_ff.chan == req_chan.channel)
            hazard = 1'b1;
         if (s2_valid_ff && s2_tag_ff.chan_ok && s2_tag_ff.chan == req_chan.channel)
            hazard = 1'b1;
         if (s3_valid_ff && s3_tag_ff.chan_ok && s3_tag_ff.chan == req_chan.channel)
            hazard = 1'b1;
         if (s4_valid_ff && s4_tag_ff.chan_ok && s4_tag_ff.chan == req_chan.channel)
            hazard = 1'b1;
         if (s5_valid_ff && s5_tag_ff.chan_ok && s5_tag_ff.chan == req_chan.channel)
            hazard = 1'b1;
      end
   end

   assign req_chan.ready = load1 && !hazard;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // ---------------------------------------------------------------
   // history memory with per-channel valid bits
   logic                 entry_valid_ff [CHANNELS];
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   hist_entry_type       wr_entry;
   logic [ENTRY_W-1:0]   rd_data;
   logic                 s1_hist_ok_ff;

   bqiir_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CHANNELS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (req_fire),
      .rd_addr (req_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            entry_valid_ff[i] <= 1'b0;
         end
      end else if (wr_en) begin
         entry_valid_ff[wr_addr] <= 1'b1;
      end
   end

   // ---------------------------------------------------------------
   // stage 1: memory read in flight
   tag_type s1_tag_in;

   assign s1_valid_in = load1 ? req_fire : s1_valid_ff;

   always_comb begin
      s1_tag_in         = '0;
      s1_tag_in.chan    = req_chan.channel;
      s1_tag_in.chan_ok = req_ok;
      s1_tag_in.x       = req_x;
   end

   always_ff @(posedge clock) begin
      if (load1) begin
         s1_tag_ff     <= s1_tag_in;
         s1_hist_ok_ff <= req_ok && entry_valid_ff[req_addr];
      end
   end

   // ---------------------------------------------------------------
   // stage 2: products
   hist_entry_type                  hist_sel;
   tag_type                         s2_tag_in;
   logic signed [HIST_W-GUARD_SPLIT-1:0] y1_hi, y2_hi;
   logic signed [GUARD_SPLIT:0]          y1_lo, y2_lo;
   logic signed [PX_W-1:0] s2_pb0_ff, s2_pb1_ff, s2_pb2_ff;
   logic signed [PH_W-1:0] s2_pa1h_ff, s2_pa2h_ff;
   logic signed [PL_W-1:0] s2_pa1l_ff, s2_pa2l_ff;

   assign hist_sel = s1_hist_ok_ff ? hist_entry_type'(rd_data) : '0;
   assign y1_hi    = hist_sel.y1[HIST_W-1:GUARD_SPLIT];
   assign y2_hi    = hist_sel.y2[HIST_W-1:GUARD_SPLIT];
   assign y1_lo    = $signed({1'b0, hist_sel.y1[GUARD_SPLIT-1:0]});
   assign y2_lo    = $signed({1'b0, hist_sel.y2[GUARD_SPLIT-1:0]});

   assign s2_valid_in = load2 ? s1_valid_ff : s2_valid_ff;

   // tag picks up the history that the memory returned
   always_comb begin
      s2_tag_in    = s1_tag_ff;
      s2_tag_in.x1 = hist_sel.x1;
      s2_tag_in.y1 = hist_sel.y1;
   end

   always_ff @(posedge clock) begin
      if (load2) begin
         s2_tag_ff    <= s2_tag_in;
         s2_pb0_ff    <= PX_W'(b0_ff) * PX_W'(s1_tag_ff.x);
         s2_pb1_ff    <= PX_W'(b1_ff) * PX_W'(hist_sel.x1);
         s2_pb2_ff    <= PX_W'(b2_ff) * PX_W'(hist_sel.x2);
         s2_pa1h_ff   <= PH_W'(a1_ff) * PH_W'(y1_hi);
         s2_pa1l_ff   <= PL_W'(a1_ff) * PL_W'(y1_lo);
         s2_pa2h_ff   <= PH_W'(a2_ff) * PH_W'(y2_hi);
         s2_pa2l_ff   <= PL_W'(a2_ff) * PL_W'(y2_lo);
      end
   end

   // ---------------------------------------------------------------
   // stage 3: feed-forward sum, feedback products reassembled
   logic signed [ACC_W-1:0] s3_feed_ff, s3_back1_ff, s3_back2_ff;

   assign s3_valid_in = load3 ? s2_valid_ff : s3_valid_ff;

   always_ff @(posedge clock) begin
      if (load3) begin
         s3_tag_ff   <= s2_tag_ff;
         s3_feed_ff  <= ACC_W'(s2_pb0_ff) + ACC_W'(s2_pb1_ff) + ACC_W'(s2_pb2_ff);
         s3_back1_ff <= (ACC_W'(s2_pa1h_ff) <<< GUARD_SPLIT) + ACC_W'(s2_pa1l_ff);
         s3_back2_ff <= (ACC_W'(s2_pa2h_ff) <<< GUARD_SPLIT) + ACC_W'(s2_pa2l_ff);
      end
   end

   // ---------------------------------------------------------------
   // stage 4: full accumulator
   logic signed [ACC_W-1:0] s4_acc_ff;

   assign s4_valid_in = load4 ? s3_valid_ff : s4_valid_ff;

   always_ff @(posedge clock) begin
      if (load4) begin
         s4_tag_ff <= s3_tag_ff;
         s4_acc_ff <= s3_feed_ff - s3_back1_ff - s3_back2_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 5: drop fraction, rounding toward zero
   logic                    acc_round_up;
   logic signed [ACC_W-1:0] s5_y_ff;

   assign acc_round_up = s4_acc_ff[ACC_W-1] && (|s4_acc_ff[COEF_FRAC_BITS-1:0]);
   assign s5_valid_in  = load5 ? s4_valid_ff : s5_valid_ff;

   always_ff @(posedge clock) begin
      if (load5) begin
         s5_tag_ff <= s4_tag_ff;
         s5_y_ff   <= (s4_acc_ff >>> COEF_FRAC_BITS) + $signed(ACC_W'(acc_round_up));
      end
   end

   // ---------------------------------------------------------------
   // saturation, history write-back and response register
   logic signed [ACC_W-1:0] y_hist, y_out, out_max, out_min;
   logic                    y_clip;
   sample_type              rsp_sample_ff;
   logic                    rsp_clipped_ff;

   assign out_max = mode_ff ? S32_MAX : S16_MAX;
   assign out_min = mode_ff ? S32_MIN : S16_MIN;

   always_comb begin
      if (s5_y_ff > HIST_MAX) begin
         y_hist = HIST_MAX;
      end else if (s5_y_ff < HIST_MIN) begin
         y_hist = HIST_MIN;
      end else begin
         y_hist = s5_y_ff;
      end
      y_clip = 1'b1;
      if (s5_y_ff > out_max) begin
         y_out = out_max;
      end else if (s5_y_ff < out_min) begin
         y_out = out_min;
      end else begin
         y_out  = s5_y_ff;
         y_clip = 1'b0;
      end
   end

   assign wr_en   = load_out && s5_valid_ff && s5_tag_ff.chan_ok;
   assign wr_addr = ADDR_W'(s5_tag_ff.chan);

   // shifted history for the write-back
   always_comb begin
      wr_entry.x1 = s5_tag_ff.x;
      wr_entry.x2 = s5_tag_ff.x1;
      wr_entry.y1 = y_hist[HIST_W-1:0];
      wr_entry.y2 = s5_tag_ff.y1;
   end

   assign rsp_valid_in = load_out ? s5_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_sample_ff  <= y_out[SAMPLE_W-1:0];
         rsp_clipped_ff <= y_clip;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         s4_valid_ff  <= s4_valid_in;
         s5_valid_ff  <= s5_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.sample_out = rsp_sample_ff;
   assign rsp_chan.clipped    = rsp_clipped_ff;

   // ---------------------------------------------------------------
`ifndef ASSERT_OFF
   // a history read never races a write-back of the same channel
   a_no_rd_wr_clash: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_ok && wr_en) |-> (req_addr != wr_addr))
      else $error("history read and write-back hit the same channel");

   // the youngest in-flight request never shares a channel with an older one
   a_one_per_channel: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_tag_ff.chan_ok) |->
         !((s2_valid_ff && s2_tag_ff.chan_ok && s2_tag_ff.chan == s1_tag_ff.chan) ||
           (s3_valid_ff && s3_tag_ff.chan_ok && s3_tag_ff.chan == s1_tag_ff.chan) ||
           (s4_valid_ff && s4_tag_ff.chan_ok && s4_tag_ff.chan == s1_tag_ff.chan) ||
           (s5_valid_ff && s5_tag_ff.chan_ok && s5_tag_ff.chan == s1_tag_ff.chan)))
      else $error("two requests of one channel in flight");

   // in 16-bit mode every response fits in 16 signed bits
   a_mode16_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !mode_ff) |->
         ((&rsp_sample_ff[SAMPLE_W-1:15]) || !(|rsp_sample_ff[SAMPLE_W-1:15])))
      else $error("16-bit mode response out of range");
`endif

endmodule

// ----- tb/tb_biquad_iir_filter_multichannel_core.sv -----
`timescale 1ns / 100ps

module tb_biquad_iir_filter_multichannel_core;
   import bqiir_pkg::*;

   localparam int CHANNELS  = CHANNELS_DEFAULT;
   localparam int COEF_FRAC = COEF_FRAC_DEFAULT;
   localparam int RANDOM_SETS     = 8;
   localparam int ITEMS_PER_SET   = 120;
   localparam int MAX_REPORTED    = 10;
   localparam int SETTLE_CYCLES   = 10;

   // register indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_B = 3'd7;

   // history saturation bounds and quotient limit
   localparam longint HIST_MAX = (64'sd1 <<< (HIST_W - 1)) - 1;
   localparam longint HIST_MIN = -HIST_MAX - 1;
   localparam logic signed [127:0] QUOT_LIMIT = 128'sd1 <<< 62;

   typedef struct {
      logic [CHAN_W-1:0] channel;
      sample_type        sample;
      bit                drain;
   } filter_request_type;

   typedef struct {
      sample_type sample_out;
      logic       clipped;
   } filter_result_type;

   logic clock = 1'b0;
   logic reset;

   bqiir_req_if req_chan ();
   bqiir_rsp_if rsp_chan ();
   bqiir_csr_if csr_chan ();

   biquad_iir_filter_multichannel_core #(
      .CHANNELS       (CHANNELS),
      .COEF_FRAC_BITS (COEF_FRAC)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #2 clock = ~clock;

   // predictor copy of the registers and per-channel history
   coef_type gain_now, gain_prev, gain_prev2, back_prev, back_prev2;
   logic     width_mode;
   longint   in_hist1 [CHANNELS];
   longint   in_hist2 [CHANNELS];
   longint   out_hist1 [CHANNELS];
   longint   out_hist2 [CHANNELS];

   filter_request_type pending_requests [$];
   filter_result_type  expected_outputs [$];
   int  queued_count   = 0;
   int  accepted_count = 0;
   int  response_count = 0;
   int  error_count    = 0;
   bit  quiet_phase    = 1'b0;

   function automatic logic signed [127:0] widen(input longint v);
      widen = v;
   endfunction

   function automatic longint saturate(input longint v, input longint lo, input longint hi,
                                       output bit hit);
      hit = 1'b0;
      if (v > hi) begin
         hit = 1'b1;
         return hi;
      end
      if (v < lo) begin
         hit = 1'b1;
         return lo;
      end
      return v;
   endfunction

   // filter one sample through the channel's history, then update that history
   function automatic filter_result_type filter_sample(input logic [CHAN_W-1:0] chan,
                                                       input sample_type raw);
      logic signed [127:0] acc, mag, quot;
      longint x, x1, x2, y1, y2, y, out_lo, out_hi;
      bit hit, hist_hit;
      filter_result_type res;
      // 16-bit mode uses only the low half, sign-extended
      x = width_mode ? longint'(raw) : longint'($signed(raw[15:0]));
      x1 = 0;
      x2 = 0;
      y1 = 0;
      y2 = 0;
      if (chan < CHANNELS) begin
         x1 = in_hist1[chan];
         x2 = in_hist2[chan];
         y1 = out_hist1[chan];
         y2 = out_hist2[chan];
      end
      acc = widen(gain_now) * widen(x) + widen(gain_prev) * widen(x1)
          + widen(gain_prev2) * widen(x2) - widen(back_prev) * widen(y1)
          - widen(back_prev2) * widen(y2);
      // divide with truncation toward zero
      mag = acc[127] ? -acc : acc;
      quot = mag >> COEF_FRAC;
      if (quot > QUOT_LIMIT)
         quot = QUOT_LIMIT;
      y = longint'(quot[63:0]);
      if (acc[127])
         y = -y;
      out_lo = width_mode ? SAT32_MIN : SAT16_MIN;
      out_hi = width_mode ? SAT32_MAX : SAT16_MAX;
      res.sample_out = sample_type'(saturate(y, out_lo, out_hi, hit));
      res.clipped = hit;
      if (chan < CHANNELS) begin
         in_hist2[chan]  = x1;
         in_hist1[chan]  = x;
         out_hist2[chan] = y1;
         out_hist1[chan] = saturate(y, HIST_MIN, HIST_MAX, hist_hit);
      end
      return res;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         return 0;
      if (pick < 92)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic coef_type random_gain();
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0: return coef_type'(SAT32_MIN);
         1: return coef_type'(SAT32_MAX);
         2: return '0;
         3, 4, 5, 6: return coef_type'(int'($urandom_range(0, 32'h1000_0000)) - 32'h0800_0000);
         default: return coef_type'($urandom());
      endcase
   endfunction

   function automatic sample_type random_sample();
      int pick;
      pick = $urandom_range(0, 19);
      case (pick)
         0: return sample_type'(SAT32_MAX);
         1: return sample_type'(SAT32_MIN);
         2: return sample_type'(SAT16_MAX);
         3: return sample_type'(SAT16_MIN);
         4, 5, 6: return sample_type'(int'($urandom_range(0, 2000)) - 1000);
         default: return sample_type'($urandom());
      endcase
   endfunction

   task automatic queue_request(input logic [CHAN_W-1:0] chan, input sample_type sample,
                                input bit drain);
      filter_request_type item;
      item.channel = chan;
      item.sample  = sample;
      item.drain   = drain;
      pending_requests.push_back(item);
      queued_count++;
   endtask

   task automatic wait_drained();
      while (accepted_count != queued_count || expected_outputs.size() != 0)
         @(posedge clock);
   endtask

   // register write; the predictor copy follows at acceptance
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      @(posedge clock);
      while (csr_chan.ready !== 1'b1)
         @(posedge clock);
      csr_chan.valid <= 1'b0;
      case (idx)
         CSR_FEED_GAIN_NOW:     gain_now   = value;
         CSR_FEED_GAIN_PREV:    gain_prev  = value;
         CSR_FEED_GAIN_PREV2:   gain_prev2 = value;
         CSR_BACK_GAIN_PREV:    back_prev  = value;
         CSR_BACK_GAIN_PREV2:   back_prev2 = value;
         CSR_SAMPLE_WIDTH_MODE: width_mode = value[0];
         default: ;
      endcase
   endtask

   // request driver
   filter_request_type req_item;
   int req_gap;

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid     <= 1'b0;
         req_chan.channel   <= '0;
         req_chan.sample_in <= '0;
         req_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_outputs.push_back(filter_sample(req_item.channel, req_item.sample));
            accepted_count++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_chan.valid <= 1'b0;
            end else if (pending_requests.size() > 0 &&
                         !(pending_requests[0].drain && expected_outputs.size() > 0)) begin
               req_item = pending_requests.pop_front();
               req_chan.valid     <= 1'b1;
               req_chan.channel   <= req_item.channel;
               req_chan.sample_in <= req_item.sample;
               req_gap = quiet_phase ? 0 : idle_length();
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and checker
   filter_result_type want;
   int rsp_stall;

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            response_count++;
            if (expected_outputs.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTED)
                  $display("%0t: response %0d with no request pending: %s%0d clipped %0b",
                           $realtime, response_count, "sample_out ", rsp_chan.sample_out,
                           rsp_chan.clipped);
            end else begin
               want = expected_outputs.pop_front();
               if (rsp_chan.sample_out !== want.sample_out || rsp_chan.clipped !== want.clipped)
               begin
                  error_count++;
                  if (error_count <= MAX_REPORTED)
                     $display("%0t: response %0d mismatch: %s%0d got %0d, %s%0b got %0b",
                              $realtime, response_count, "sample_out exp ", want.sample_out,
                              rsp_chan.sample_out, "clipped exp ", want.clipped,
                              rsp_chan.clipped);
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (!quiet_phase && $urandom_range(0, 3) == 0)
               rsp_stall = idle_length();
         end
      end
   end

   // stimulus and verdict
   initial begin
      logic [CHAN_W-1:0] chan;
      int set_idx, n;

      reset = 1'b1;
      csr_chan.valid     = 1'b0;
      csr_chan.index     = '0;
      csr_chan.data      = '0;
      gain_now   = coef_type'(64'sd1 <<< COEF_FRAC);
      gain_prev  = '0;
      gain_prev2 = '0;
      back_prev  = '0;
      back_prev2 = '0;
      width_mode = 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
         in_hist1[c]  = 0;
         in_hist2[c]  = 0;
         out_hist1[c] = 0;
         out_hist2[c] = 0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset settings, 16-bit mode: extremes and ignored upper halves
      queue_request(3'd0, 32'h0000_0000, 1'b0);
      queue_request(3'd1, 32'h0000_7FFF, 1'b0);
      queue_request(3'd2, 32'hFFFF_8000, 1'b0);
      queue_request(3'd3, 32'h7FFF_8000, 1'b0);
      queue_request(3'd4, 32'h0000_FFFF, 1'b0);
      queue_request(3'd5, 32'h8000_7FFF, 1'b0);
      queue_request(3'd6, 32'h7FFF_FFFF, 1'b0);
      queue_request(3'd7, 32'h8000_0000, 1'b0);
      wait_drained();

      // extreme gains, 32-bit mode: clipping and history saturation
      write_register(CSR_FEED_GAIN_NOW,     32'h7FFF_FFFF);
      write_register(CSR_FEED_GAIN_PREV,    32'h8000_0000);
      write_register(CSR_FEED_GAIN_PREV2,   32'h7FFF_FFFF);
      write_register(CSR_BACK_GAIN_PREV,    32'h8000_0000);
      write_register(CSR_BACK_GAIN_PREV2,   32'h8000_0000);
      write_register(CSR_SAMPLE_WIDTH_MODE, 32'h0000_0001);
      for (n = 0; n < 6; n++)
         queue_request(3'd0, n[0] ? 32'h8000_0000 : 32'h7FFF_FFFF, 1'b0);
      queue_request(3'd1, 32'h7FFF_FFFF, 1'b0);
      queue_request(3'd1, 32'h7FFF_FFFF, 1'b0);
      queue_request(3'd7, 32'h0000_0000, 1'b0);
      wait_drained();

      // unmapped indexes are ignored; back to 16-bit mode with history kept
      write_register(CSR_UNMAPPED_A, 32'hFFFF_FFFF);
      write_register(CSR_UNMAPPED_B, 32'hFFFF_FFFF);
      write_register(CSR_SAMPLE_WIDTH_MODE, 32'hFFFF_FFFE);
      queue_request(3'd0, 32'h0000_0000, 1'b0);
      queue_request(3'd0, 32'h0000_1234, 1'b0);
      queue_request(3'd1, 32'h0000_0000, 1'b0);
      queue_request(3'd2, 32'hFFFF_FFFF, 1'b0);

      // random settings: stable filters on some sets, wild gains on the rest
      chan = '0;
      for (set_idx = 0; set_idx < RANDOM_SETS; set_idx++) begin
         wait_drained();
         quiet_phase = (set_idx == 2 || set_idx == 5);
         if (set_idx % 3 == 1) begin
            write_register(CSR_FEED_GAIN_NOW,   int'($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000);
            write_register(CSR_FEED_GAIN_PREV,  int'($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000);
            write_register(CSR_FEED_GAIN_PREV2, int'($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000);
            write_register(CSR_BACK_GAIN_PREV,  int'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000);
            write_register(CSR_BACK_GAIN_PREV2, $urandom_range(0, 32'h0800_0000));
         end else begin
            write_register(CSR_FEED_GAIN_NOW,   random_gain());
            write_register(CSR_FEED_GAIN_PREV,  random_gain());
            write_register(CSR_FEED_GAIN_PREV2, random_gain());
            write_register(CSR_BACK_GAIN_PREV,  random_gain());
            write_register(CSR_BACK_GAIN_PREV2, random_gain());
         end
         write_register(CSR_SAMPLE_WIDTH_MODE, COEF_W'(set_idx[0]));
         for (n = 0; n < ITEMS_PER_SET; n++) begin
            // occasional same-channel runs hit the history hazard
            if ($urandom_range(0, 4) != 0)
               chan = CHAN_W'($urandom_range(0, CHANNELS - 1));
            queue_request(chan, random_sample(), set_idx == 3 && n == ITEMS_PER_SET / 2);
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_outputs.size() == 0)
         $display("tb_biquad_iir_filter_multichannel_core: PASS");
      else
         $display("tb_biquad_iir_filter_multichannel_core: FAIL");
      $finish;
   end

   // watchdog
   initial begin
      #4ms;
      $display("tb_biquad_iir_filter_multichannel_core: FAIL");
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/bqiir_pkg.sv
sv/bqiir_if.sv
sv/bqiir_ram.sv
sv/biquad_iir_filter_multichannel_core.sv
tb/tb_biquad_iir_filter_multichannel_core.sv
